FILE: src/fog_factor_calculator_defines.svh
// Assertion macros shared by the fog factor checker.
`ifndef FOG_FACTOR_CALCULATOR_DEFINES_SVH
`define FOG_FACTOR_CALCULATOR_DEFINES_SVH

// Implication checked at every clock edge outside reset.
`define FOGF_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("fog factor check failed");

// Condition that must never hold outside reset.
`define FOGF_ASSERT_NEVER(label, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("fog factor forbidden condition");

`endif

FILE: src/fogf_pkg.sv
// Types and constants of the fog factor pipeline.
`default_nettype none
package fogf_pkg;

  // register indexes of the configuration port
  typedef logic [1:0] cfg_idx_t;
  localparam cfg_idx_t REG_NEAR    = 2'd0;
  localparam cfg_idx_t REG_FAR     = 2'd1;
  localparam cfg_idx_t REG_DENSITY = 2'd2;

  localparam logic [17:0] ONE_Q16      = 18'd65536;
  localparam logic [30:0] ONE_Q30      = 31'd1073741824;
  localparam logic [39:0] X_LIMIT      = 40'd393216;   // 6.0 in Q16
  localparam int          SERIES_TERMS = 16;
  localparam int          DIV_BITS     = 8;
  localparam int          LATENCY      = 57;

  // fields that travel with every item down the pipeline
  typedef struct packed {
    logic [2:0] row;
    logic [9:0] idx;
    logic       lin;     // linear mode
    logic       bad;     // empty or negative span
    logic       xbig;    // exponent argument at or above 6.0
    logic       lzero;   // distance at or beyond far
    logic       lsat;    // distance at or before near
    logic [7:0] lq;      // linear quotient
  } side_t;

endpackage
`default_nettype wire

FILE: src/fog_factor_calculator.sv
// Fog factor pipeline: one fog byte per distance, one item per cycle.
//
// Usage:
//   Pulse start with in_fog_state and in_distance; busy is always low, so an
//   item is transferred at every clock edge where start is high. Each item
//   gives one result, shown for one cycle with out_valid high, carrying the
//   row, the index, the fog byte and bad_span. Throughput is one item per
//   cycle; the depth is set by the sixteen-term exponential series, three
//   stages per term (multiply, reciprocal multiply, correction), followed by
//   three squaring stages and the byte scaling. Linear mode uses an
//   eight-stage restoring divider that runs beside the series. The receiver
//   cannot stall: results leave on schedule. Configuration (near, far,
//   density) is written through cfg_we, cfg_index and cfg_data while no item
//   is in flight; writes to unknown indexes are dropped. Synchronous reset
//   empties the pipeline and restores near=0, far=65535, density=0.
`default_nettype none
module fog_factor_calculator (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [2:0]         in_fog_state,
  input  wire logic [9:0]         in_distance,
  output logic                    out_valid,
  output logic [2:0]              out_row_out,
  output logic [9:0]              out_index_out,
  output logic [7:0]              out_fog_byte,
  output logic                    out_bad_span,
  input  wire logic               cfg_we,
  input  wire fogf_pkg::cfg_idx_t cfg_index,
  input  wire logic [17:0]        cfg_data
);
  import fogf_pkg::*;

  localparam int NSTG = 3 * SERIES_TERMS;

  // configuration registers
  logic [15:0] near_r, far_r;
  logic [17:0] dens_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      near_r <= '0;
      far_r  <= 16'hFFFF;
      dens_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_NEAR:    near_r <= cfg_data[15:0];
        REG_FAR:     far_r  <= cfg_data[15:0];
        REG_DENSITY: dens_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  // stage A: mode decode, first products, linear span checks
  logic        a_v_r;
  side_t       a_side_r, a_side_nxt;
  logic [25:0] a_xe_r;
  logic [27:0] a_yv_r;
  logic        a_exp2_r;
  logic [15:0] a_num_r, a_den_r;
  logic [17:0] dm1;
  logic [15:0] dd, num_a, den_a;

  always_comb begin
    dm1 = dens_r - ONE_Q16;
    dd  = {in_distance, 6'b0};
    den_a = far_r - near_r;
    num_a = far_r - dd;
    a_side_nxt       = '0;
    a_side_nxt.row   = in_fog_state;
    a_side_nxt.idx   = in_distance;
    a_side_nxt.lin   = (dens_r == '0);
    a_side_nxt.bad   = (dens_r == '0) && (far_r <= near_r);
    a_side_nxt.lzero = (dd >= far_r);
    a_side_nxt.lsat  = (num_a >= den_a);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) a_v_r <= 1'b0;
    else        a_v_r <= start && !busy;
  end

  always_ff @(posedge clk) begin
    a_side_r <= a_side_nxt;
    a_xe_r   <= 26'(dens_r[15:0]) * 26'(in_distance);
    a_yv_r   <= 28'(dm1) * 28'(in_distance);
    a_exp2_r <= (dens_r[17:16] != 2'b00);
    a_num_r  <= num_a;
    a_den_r  <= den_a;
  end

  // stage B: square for exp2, scale linear numerator and divisor
  logic        b_v_r;
  side_t       b_side_r;
  logic [25:0] b_xe_r;
  logic        b_exp2_r;
  logic [55:0] b_y2_r;
  logic [27:0] b_n_r;
  logic [19:0] b_dv_r;

  always_ff @(posedge clk) begin
    if (!rst_n) b_v_r <= 1'b0;
    else        b_v_r <= a_v_r;
  end

  always_ff @(posedge clk) begin
    b_side_r <= a_side_r;
    b_xe_r   <= a_xe_r;
    b_exp2_r <= a_exp2_r;
    b_y2_r   <= 56'(a_yv_r) * 56'(a_yv_r);
    b_n_r    <= 28'(a_num_r) * 28'd2559;
    b_dv_r   <= 20'(a_den_r) * 20'd10;
  end

  // stage C: select exponent argument, range check
  logic        c_v_r;
  side_t       c_side_r, c_side_nxt;
  logic [18:0] c_x_r;
  logic [39:0] x_sel;

  always_comb begin
    x_sel = b_exp2_r ? b_y2_r[55:16] : 40'(b_xe_r);
    c_side_nxt = b_side_r;
    c_side_nxt.xbig = (x_sel >= X_LIMIT);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) c_v_r <= 1'b0;
    else        c_v_r <= b_v_r;
  end

  always_ff @(posedge clk) begin
    c_side_r <= c_side_nxt;
    c_x_r    <= x_sel[18:0];
  end

  // linear divider: one quotient bit per stage, runs beside the series
  logic [27:0] dq_rem_r [DIV_BITS];
  logic [19:0] dq_dv_r  [DIV_BITS];
  logic [7:0]  dq_q_r   [DIV_BITS];

  for (genvar j = 0; j < DIV_BITS; j++) begin : g_div
    localparam int SH = DIV_BITS - 1 - j;
    logic [27:0] rem_in, trial;
    logic [19:0] dv_in;
    logic [7:0]  q_in;
    logic        take;
    if (j == 0) begin : g_first
      assign rem_in = b_n_r;
      assign dv_in  = b_dv_r;
      assign q_in   = '0;
    end else begin : g_next
      assign rem_in = dq_rem_r[j-1];
      assign dv_in  = dq_dv_r[j-1];
      assign q_in   = dq_q_r[j-1];
    end
    assign trial = 28'(dv_in) << SH;
    assign take  = (rem_in >= trial);
    always_ff @(posedge clk) begin
      dq_rem_r[j] <= take ? rem_in - trial : rem_in;
      dq_dv_r[j]  <= dv_in;
      dq_q_r[j]   <= {q_in[6:0], take};
    end
  end

  // series stages: three per term
  logic        st_v_r     [NSTG];
  side_t       st_side_r  [NSTG];
  logic [18:0] st_x_r     [NSTG];
  logic [31:0] st_plus_r  [NSTG];
  logic [31:0] st_minus_r [NSTG];
  logic [49:0] p_r        [SERIES_TERMS];
  logic [30:0] qa_r       [SERIES_TERMS];
  logic [63:0] m_r        [SERIES_TERMS];
  logic [30:0] term_r     [SERIES_TERMS];

  for (genvar k = 1; k <= SERIES_TERMS; k++) begin : g_term
    localparam int          K   = k;
    localparam int          S0  = 3 * (k - 1);
    localparam logic [32:0] RCP = 33'((64'd1 << 32) / K);
    logic        v_in;
    side_t       side_in, side_m;
    logic [18:0] x_in;
    logic [31:0] plus_in, minus_in, plus_nx, minus_nx;
    logic [30:0] term_in, q0, term_nx;
    logic [34:0] qk, rem;

    if (k == 1) begin : g_src0
      assign v_in     = c_v_r;
      assign side_in  = c_side_r;
      assign x_in     = c_x_r;
      assign plus_in  = 32'(ONE_Q30);
      assign minus_in = '0;
      assign term_in  = ONE_Q30;
    end else begin : g_srcn
      assign v_in     = st_v_r[S0-1];
      assign side_in  = st_side_r[S0-1];
      assign x_in     = st_x_r[S0-1];
      assign plus_in  = st_plus_r[S0-1];
      assign minus_in = st_minus_r[S0-1];
      assign term_in  = term_r[k-2];
    end

    // the linear quotient joins the side fields here
    if (k == 3) begin : g_join
      always_comb begin
        side_m    = st_side_r[S0];
        side_m.lq = dq_q_r[DIV_BITS-1];
      end
    end else begin : g_nojoin
      assign side_m = st_side_r[S0];
    end

    // floor(a / K) from reciprocal estimate plus one correction
    assign q0      = m_r[k-1][62:32];
    assign qk      = 35'(q0) * 35'(K);
    assign rem     = 35'(qa_r[k-1]) - qk;
    assign term_nx = q0 + 31'(rem >= 35'(K));

    if (K % 2 == 1) begin : g_odd
      assign minus_nx = st_minus_r[S0+1] + 32'(term_nx);
      assign plus_nx  = st_plus_r[S0+1];
    end else begin : g_even
      assign plus_nx  = st_plus_r[S0+1] + 32'(term_nx);
      assign minus_nx = st_minus_r[S0+1];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        st_v_r[S0]   <= 1'b0;
        st_v_r[S0+1] <= 1'b0;
        st_v_r[S0+2] <= 1'b0;
      end else begin
        st_v_r[S0]   <= v_in;
        st_v_r[S0+1] <= st_v_r[S0];
        st_v_r[S0+2] <= st_v_r[S0+1];
      end
    end

    always_ff @(posedge clk) begin
      // product with the argument
      st_side_r[S0]  <= side_in;
      st_x_r[S0]     <= x_in;
      st_plus_r[S0]  <= plus_in;
      st_minus_r[S0] <= minus_in;
      p_r[k-1]       <= 50'(term_in) * 50'(x_in);
      // divide by 8 * 2^16 by shift, then reciprocal of K
      st_side_r[S0+1]  <= side_m;
      st_x_r[S0+1]     <= st_x_r[S0];
      st_plus_r[S0+1]  <= st_plus_r[S0];
      st_minus_r[S0+1] <= st_minus_r[S0];
      qa_r[k-1]        <= p_r[k-1][49:19];
      m_r[k-1]         <= 64'(p_r[k-1][49:19]) * 64'(RCP);
      // corrected term, accumulate by sign
      st_side_r[S0+2]  <= st_side_r[S0+1];
      st_x_r[S0+2]     <= st_x_r[S0+1];
      st_plus_r[S0+2]  <= plus_nx;
      st_minus_r[S0+2] <= minus_nx;
      term_r[k-1]      <= term_nx;
    end
  end

  // difference of the sums, then three squarings
  logic        e_v_r [4];
  side_t       e_side_r [4];
  logic [30:0] e_r [4];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 4; i++) e_v_r[i] <= 1'b0;
    end else begin
      e_v_r[0] <= st_v_r[NSTG-1];
      for (int i = 1; i < 4; i++) e_v_r[i] <= e_v_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    e_side_r[0] <= st_side_r[NSTG-1];
    e_r[0]      <= (st_plus_r[NSTG-1] > st_minus_r[NSTG-1]) ?
                   31'(st_plus_r[NSTG-1] - st_minus_r[NSTG-1]) : '0;
    for (int i = 1; i < 4; i++) begin
      e_side_r[i] <= e_side_r[i-1];
      e_r[i]      <= 31'((62'(e_r[i-1]) * 62'(e_r[i-1])) >> 30);
    end
  end

  // scale by 2559 / 2^30
  logic        s_v_r;
  side_t       s_side_r;
  logic [11:0] s_a2_r;
  logic [42:0] a2_full;

  assign a2_full = 43'(e_r[3]) * 43'd2559;

  always_ff @(posedge clk) begin
    if (!rst_n) s_v_r <= 1'b0;
    else        s_v_r <= e_v_r[3];
  end

  always_ff @(posedge clk) begin
    s_side_r <= e_side_r[3];
    s_a2_r   <= a2_full[41:30];
  end

  // divide by ten, final byte selection
  logic [24:0] div10;
  logic [8:0]  eb9;
  logic [7:0]  ebyte, fbyte;

  always_comb begin
    div10 = 25'(s_a2_r) * 25'd6554;
    eb9   = div10[24:16];
    ebyte = (eb9 > 9'd255) ? 8'hFF : eb9[7:0];
    if (s_side_r.lin) begin
      if (s_side_r.bad || s_side_r.lzero) fbyte = '0;
      else if (s_side_r.lsat)             fbyte = 8'hFF;
      else                                fbyte = s_side_r.lq;
    end else begin
      fbyte = s_side_r.xbig ? 8'h00 : ebyte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid <= 1'b0;
    else        out_valid <= s_v_r;
  end

  always_ff @(posedge clk) begin
    out_row_out   <= s_side_r.row;
    out_index_out <= s_side_r.idx;
    out_fog_byte  <= fbyte;
    out_bad_span  <= s_side_r.bad;
  end

endmodule
`default_nettype wire

FILE: src/fogf_checker.sv
// Port-level checker for the fog factor pipeline, bound to the top level.
`default_nettype none
`include "fog_factor_calculator_defines.svh"
module fogf_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       start,
  input wire logic       busy,
  input wire logic [2:0] in_fog_state,
  input wire logic [9:0] in_distance,
  input wire logic       out_valid,
  input wire logic [2:0] out_row_out,
  input wire logic [9:0] out_index_out,
  input wire logic [7:0] out_fog_byte,
  input wire logic       out_bad_span
);
  import fogf_pkg::*;

  // every transfer yields a result after the fixed latency
  `FOGF_ASSERT_IMPL(a_result_follows, start && !busy, ##LATENCY out_valid)
  // no result without a matching transfer
  `FOGF_ASSERT_IMPL(a_no_orphan, out_valid, $past(start && !busy, LATENCY))
  // row and index come back with their item
  `FOGF_ASSERT_IMPL(a_tags, out_valid, (out_index_out == $past(in_distance, LATENCY)) && (out_row_out == $past(in_fog_state, LATENCY)))
  // a bad span always reads as zero fog
  `FOGF_ASSERT_NEVER(a_bad_zero, out_valid && out_bad_span && (out_fog_byte != 8'd0))

endmodule

bind fog_factor_calculator fogf_checker u_fogf_checker (.*);
`default_nettype wire

FILE: tb/sv/fog_factor_calculator_test.sv
// Self-checking testbench for the fog factor pipeline.
`timescale 1ns / 100ps
`default_nettype none
module fog_factor_calculator_test;
  import fogf_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  // index outside the register list, writes to it are dropped
  localparam cfg_idx_t REG_NONE = 2'd3;

  typedef struct packed {
    logic [2:0] row;
    logic [9:0] distance;
  } fog_item_t;

  typedef struct packed {
    logic [2:0] row;
    logic [9:0] idx;
    logic [7:0] fbyte;
    logic       bad;
  } fog_entry_t;

  logic clk;
  logic rst_n;
  logic start = 1'b0;
  logic busy;
  logic [2:0] in_fog_state = '0;
  logic [9:0] in_distance = '0;
  logic out_valid;
  logic [2:0] out_row_out;
  logic [9:0] out_index_out;
  logic [7:0] out_fog_byte;
  logic out_bad_span;
  logic cfg_we;
  cfg_idx_t cfg_index;
  logic [17:0] cfg_data;

  fog_factor_calculator dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_fog_state(in_fog_state), .in_distance(in_distance),
    .out_valid(out_valid), .out_row_out(out_row_out),
    .out_index_out(out_index_out), .out_fog_byte(out_fog_byte),
    .out_bad_span(out_bad_span), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // local copy of the registers
  logic [15:0] near_q6;
  logic [15:0] far_q6;
  logic [17:0] dens_q16;

  fog_item_t  pending_items[$];
  fog_entry_t expected_entries[$];
  int  errors = 0;
  int  cycles = 0;
  int  gap_pct;
  bit  feeding;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // floor(255.9 * exp(-x)), x in Q16
  function automatic logic [7:0] exp_fog_byte(logic [63:0] x);
    logic [63:0] term, plus, minus, e, b;
    if (x >= 64'd393216) return 8'd0;
    term = 64'd1 << 30;
    plus = term;
    minus = 0;
    for (int k = 1; k <= 16; k++) begin
      term = (term * x) / (64'(k) * 64'd8 * 64'd65536);
      if (k % 2 == 1) minus += term;
      else plus += term;
    end
    e = (plus > minus) ? plus - minus : 64'd0;
    for (int s = 0; s < 3; s++) e = (e * e) >> 30;
    b = (64'd2559 * e) / (64'd10 << 30);
    return (b > 255) ? 8'd255 : b[7:0];
  endfunction

  function automatic fog_entry_t fog_entry_for(fog_item_t it);
    fog_entry_t r;
    logic [63:0] den, dd, num, y;
    r.row = it.row;
    r.idx = it.distance;
    r.fbyte = 8'd0;
    r.bad = 1'b0;
    if (dens_q16 == 0) begin
      if (far_q6 <= near_q6) begin
        r.bad = 1'b1;
      end else begin
        den = far_q6 - near_q6;
        dd = 64'(it.distance) << 6;
        if (dd < far_q6) begin
          num = far_q6 - dd;
          if (num >= den) r.fbyte = 8'd255;
          else r.fbyte = 8'((64'd2559 * num) / (64'd10 * den));
        end
      end
    end else if (dens_q16 < 18'd65536) begin
      r.fbyte = exp_fog_byte(64'(dens_q16) * 64'(it.distance));
    end else begin
      y = (64'(dens_q16) - 64'd65536) * 64'(it.distance);
      r.fbyte = exp_fog_byte((y * y) >> 16);
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (rst_n && start && !busy) begin
      expected_entries.push_back(fog_entry_for({in_fog_state, in_distance}));
    end
    // monitor
    if (rst_n && out_valid) begin
      if (expected_entries.size() == 0) begin
        report_mismatch("unexpected result, row", out_row_out, -1);
      end else begin
        fog_entry_t w;
        w = expected_entries.pop_front();
        if (out_row_out !== w.row) report_mismatch("row_out", out_row_out, w.row);
        if (out_index_out !== w.idx) report_mismatch("index_out", out_index_out, w.idx);
        if (out_fog_byte !== w.fbyte) report_mismatch("fog_byte", out_fog_byte, w.fbyte);
        if (out_bad_span !== w.bad) report_mismatch("bad_span", out_bad_span, w.bad);
      end
    end
  end

  // driver fed from the queue; start changes once per falling edge
  always @(negedge clk) begin
    if (rst_n && feeding && pending_items.size() != 0
        && $urandom_range(99, 0) >= gap_pct) begin
      fog_item_t it;
      it = pending_items.pop_front();
      start <= 1'b1;
      in_fog_state <= it.row;
      in_distance <= it.distance;
    end else begin
      start <= 1'b0;
      in_fog_state <= 3'($urandom);
      in_distance <= 10'($urandom);
    end
  end

  // timeout
  always @(posedge clk) begin
    if (cycles >= CYCLE_LIMIT) begin
      $display("FAIL fog_factor_calculator");
      $finish;
    end
  end

  task automatic write_reg(cfg_idx_t idx, logic [17:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_NEAR) near_q6 = val[15:0];
    else if (idx == REG_FAR) far_q6 = val[15:0];
    else if (idx == REG_DENSITY) dens_q16 = val;
  endtask

  // run queued items and wait for every result, plus the pipeline depth
  task automatic drain();
    feeding = 1'b1;
    while (pending_items.size() != 0 || expected_entries.size() != 0)
      @(posedge clk);
    feeding = 1'b0;
    repeat (LATENCY + 5) @(posedge clk);
  endtask

  task automatic queue_random(int n);
    for (int i = 0; i < n; i++) begin
      fog_item_t it;
      it.row = 3'($urandom);
      case ($urandom_range(3, 0))
        0: it.distance = 10'($urandom_range(15, 0));
        1: it.distance = 10'($urandom_range(1023, 1000));
        default: it.distance = 10'($urandom);
      endcase
      pending_items.push_back(it);
    end
  endtask

  task automatic random_setting();
    logic [15:0] a, b;
    a = 16'($urandom);
    b = 16'($urandom);
    case ($urandom_range(4, 0))
      0: begin
        write_reg(REG_DENSITY, 18'd0);
        write_reg(REG_NEAR, 18'((a < b) ? a : b));
        write_reg(REG_FAR, 18'((a < b) ? b : a));
      end
      1: begin
        write_reg(REG_DENSITY, 18'd0);
        write_reg(REG_NEAR, 18'(a));
        write_reg(REG_FAR, 18'(b));
      end
      2: write_reg(REG_DENSITY, 18'($urandom_range(65535, 1)));
      3: write_reg(REG_DENSITY, 18'($urandom_range(300, 1)));
      default: write_reg(REG_DENSITY, 18'($urandom_range(131072, 65536)));
    endcase
    if ($urandom_range(9, 0) == 0) write_reg(REG_NONE, 18'($urandom));
  endtask

  initial begin
    feeding = 1'b0;
    gap_pct = 0;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = REG_NEAR;
    cfg_data = '0;
    near_q6 = 16'd0;
    far_q6 = 16'hFFFF;
    dens_q16 = 18'd0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: reset settings and field extremes
    pending_items.push_back({3'd0, 10'd0});
    pending_items.push_back({3'd7, 10'd1023});
    pending_items.push_back({3'd5, 10'd512});
    drain();
    // linear with near = far: bad span
    write_reg(REG_NEAR, 18'd1000);
    write_reg(REG_FAR, 18'd1000);
    pending_items.push_back({3'd1, 10'd3});
    drain();
    // far below near, and an ignored register index
    write_reg(REG_FAR, 18'd0);
    write_reg(REG_NONE, 18'h3FFFF);
    pending_items.push_back({3'd2, 10'd3});
    drain();
    // linear ramp around near and far
    write_reg(REG_NEAR, 18'd640);
    write_reg(REG_FAR, 18'hFFFF);
    for (int d = 0; d < 4; d++) pending_items.push_back({3'(d), 10'(d * 9)});
    pending_items.push_back({3'd6, 10'd1023});
    drain();
    // exp: smallest and just under one
    write_reg(REG_DENSITY, 18'd1);
    pending_items.push_back({3'd3, 10'd1023});
    drain();
    write_reg(REG_DENSITY, 18'd65535);
    pending_items.push_back({3'd4, 10'd1});
    pending_items.push_back({3'd4, 10'd6});
    drain();
    // exp2: exactly one, exactly two, and the maximum
    write_reg(REG_DENSITY, 18'd65536);
    pending_items.push_back({3'd7, 10'd1023});
    drain();
    write_reg(REG_DENSITY, 18'd131072);
    pending_items.push_back({3'd0, 10'd1});
    pending_items.push_back({3'd1, 10'd2});
    drain();
    write_reg(REG_DENSITY, 18'h3FFFF);
    pending_items.push_back({3'd2, 10'd1});
    drain();

    // random phases across the idling patterns
    for (int p = 0; p < 25; p++) begin
      gap_pct = (p < 8) ? 24 : (p < 16) ? 56 : 0;
      random_setting();
      queue_random(50);
      drain();
    end

    if (errors == 0) begin
      $display("PASS fog_factor_calculator");
    end else begin
      $display("FAIL fog_factor_calculator");
    end
    $finish;
  end
endmodule
`default_nettype wire

FILE: files.f
+incdir+src
src/fogf_pkg.sv
src/fog_factor_calculator.sv
src/fogf_checker.sv
tb/sv/fog_factor_calculator_test.sv
